// ----- src/sps_pkg.sv -----
// Shared types and constants for the servo pulse train scheduler.
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;

  // Item kinds
  localparam logic KIND_SET   = 1'b0;
  localparam logic KIND_MATCH = 1'b1;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_PULSE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PULSE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TICKS_US  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME     = 2'd3;

  // Register reset values
  localparam logic [15:0] MIN_PULSE_RST = 16'd1000;
  localparam logic [15:0] MAX_PULSE_RST = 16'd2000;
  localparam logic [7:0]  TICKS_US_RST  = 8'd15;
  localparam logic [31:0] FRAME_RST     = 32'd300000;

  // Timing constants, microseconds
  localparam logic [6:0]  RESET_PULSE_USEC = 7'd100;
  localparam logic [15:0] MIDPOINT_USEC    = 16'd1500;

  typedef struct packed {
    logic        kind;
    logic [3:0]  channel;
    logic [15:0] pulse_usec;
  } sps_item_t;

  typedef struct packed {
    logic [31:0] next_interval;
    logic        reset_level;
    logic        clock_low;
    logic [3:0]  phase_after;
  } sps_result_t;

endpackage
`default_nettype wire

// ----- src/sps_if.sv -----
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps
`default_nettype none
interface sps_item_if;
  import sps_pkg::*;
  logic      valid;
  logic      ready;
  sps_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sps_result_if;
  import sps_pkg::*;
  logic        valid;
  logic        ready;
  sps_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/servo_pulse_train_scheduler.sv -----
// Top level: pulse table memory, frame phase sequencer and result register.
//
//  Channel  | Dir | Handshake     | Payload
//  item     | in  | valid/ready   | kind, channel, pulse_usec
//  result   | out | valid/ready   | next_interval, reset_level, clock_low, phase_after
//  cfg      | in  | write enable  | cfg_addr, cfg_wdata (no read-back)
//
// A set item is clamped on transfer and written to the pulse table if its channel is in range.
// A match item passes through table read, tick multiply, then phase update and load
// of the result register.
// The next item is taken while a finished result still waits; a match item holds in its
// last step only while the result register is full. Synchronous reset restores the
// register defaults, marks every table entry as midpoint width and returns to the reset phase.
`timescale 1ns / 1ps
`default_nettype none
module servo_pulse_train_scheduler #(
  parameter int CHANNELS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  sps_item_if.sink                            item,
  sps_result_if.source                        result,
  input  logic                                cfg_we,
  input  logic [sps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [sps_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import sps_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [3:0] CH_LIMIT    = 4'(CHANNELS);
  localparam logic [3:0] PHASE_PAUSE = 4'(CHANNELS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;

  logic [1:0]  state;
  logic [15:0] min_pulse;
  logic [15:0] max_pulse;
  logic [7:0]  ticks_us;
  logic [31:0] frame_ticks;

  logic [3:0]  phase;
  logic [31:0] pause_left;

  logic [15:0]         pulse_mem [CHANNELS];
  logic [CHANNELS-1:0] entry_valid;
  logic [15:0]         rd_data;
  logic                rd_hit;

  logic [23:0] pulse_ticks;
  logic [14:0] reset_ticks;

  logic        out_valid;
  sps_result_t out_data;

  logic        take;
  logic        take_set;
  logic        take_match;
  logic        set_ok;
  logic [15:0] us_lo;
  logic [15:0] us_clamp;
  logic [3:0]  slot;
  logic [AW-1:0] rd_addr;
  logic [15:0] width_us;
  logic        commit;

  logic [31:0] interval_next;
  logic [31:0] pause_next;
  logic [3:0]  phase_next;
  logic        rst_level_next;
  logic        clk_low_next;

  assign item.ready    = (state == ST_IDLE);
  assign take          = item.valid && item.ready;
  assign take_set      = take && (item.data.kind == KIND_SET);
  assign take_match    = take && (item.data.kind == KIND_MATCH);
  assign set_ok        = (item.data.channel < CH_LIMIT);

  // Raise to min first, then lower to max
  assign us_lo    = (item.data.pulse_usec < min_pulse) ? min_pulse : item.data.pulse_usec;
  assign us_clamp = (us_lo > max_pulse) ? max_pulse : us_lo;

  assign slot    = phase - 4'd1;
  assign rd_addr = ((phase == 4'd0) || (slot >= CH_LIMIT)) ? '0 : slot[AW-1:0];

  assign width_us = rd_hit ? rd_data : MIDPOINT_USEC;
  assign commit   = (state == ST_CALC) && (!out_valid || result.ready);

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse   <= MIN_PULSE_RST;
      max_pulse   <= MAX_PULSE_RST;
      ticks_us    <= TICKS_US_RST;
      frame_ticks <= FRAME_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MIN_PULSE: min_pulse   <= cfg_wdata[15:0];
        CFG_MAX_PULSE: max_pulse   <= cfg_wdata[15:0];
        CFG_TICKS_US:  ticks_us    <= cfg_wdata[7:0];
        CFG_FRAME:     frame_ticks <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Pulse table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (take_set && set_ok) begin
      pulse_mem[item.data.channel[AW-1:0]] <= us_clamp;
    end
    if (take_match) begin
      rd_data <= pulse_mem[rd_addr];
    end
  end

  // Unwritten entries read as the midpoint width
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_hit      <= 1'b0;
    end else begin
      if (take_set && set_ok) begin
        entry_valid[item.data.channel[AW-1:0]] <= 1'b1;
      end
      if (take_match) begin
        rd_hit <= entry_valid[rd_addr];
      end
    end
  end

  // Tick conversion
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      pulse_ticks <= width_us * ticks_us;
      reset_ticks <= RESET_PULSE_USEC * ticks_us;
    end
  end

  always_comb begin
    interval_next  = '0;
    pause_next     = pause_left;
    phase_next     = phase;
    rst_level_next = 1'b0;
    clk_low_next   = 1'b0;
    if (phase == 4'd0) begin
      interval_next  = 32'(reset_ticks);
      pause_next     = frame_ticks;
      rst_level_next = 1'b1;
      phase_next     = 4'd1;
    end else if (phase == 4'd1) begin
      // first channel shares its time with the reset pulse
      interval_next = (pulse_ticks > 24'(reset_ticks)) ?
                      32'(pulse_ticks - 24'(reset_ticks)) : '0;
      pause_next    = (pause_left > 32'(pulse_ticks)) ? pause_left - 32'(pulse_ticks) : '0;
      clk_low_next  = 1'b1;
      phase_next    = 4'd2;
    end else if (phase >= PHASE_PAUSE) begin
      interval_next = pause_left;
      phase_next    = 4'd0;
    end else begin
      interval_next = 32'(pulse_ticks);
      pause_next    = (pause_left > 32'(pulse_ticks)) ? pause_left - 32'(pulse_ticks) : '0;
      clk_low_next  = 1'b1;
      phase_next    = phase + 4'd1;
    end
  end

  // Sequencer and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= 4'd0;
      pause_left <= FRAME_RST;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (take_match) state <= ST_READ;
        ST_READ: state <= ST_CALC;
        ST_CALC: if (commit) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
      if (commit) begin
        phase      <= phase_next;
        pause_left <= pause_next;
        out_valid  <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data.next_interval <= interval_next;
      out_data.reset_level   <= rst_level_next;
      out_data.clock_low     <= clk_low_next;
      out_data.phase_after   <= phase_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/sps_checker.sv -----
// Port-level checks for the servo pulse train scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sps_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_interval,
  input logic        out_reset_level,
  input logic        out_clock_low,
  input logic [3:0]  out_phase_after
);
  import sps_pkg::*;

  // A waiting result stays valid and keeps its interval
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_interval))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Reset pulse only on the transfer that opens a frame
  a_reset_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_reset_level == (out_phase_after == 4'd1)))
    else $error("reset level does not match phase");

  a_pins_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_reset_level && out_clock_low))
    else $error("reset and clock-low together");

  // A match item keeps the block busy for the next cycle
  a_match_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_kind == KIND_MATCH) |=> !in_ready)
    else $error("match item did not occupy the sequencer");

endmodule

bind servo_pulse_train_scheduler sps_checker u_sps_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (item.valid),
  .in_ready        (item.ready),
  .in_kind         (item.data.kind),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .out_interval    (result.data.next_interval),
  .out_reset_level (result.data.reset_level),
  .out_clock_low   (result.data.clock_low),
  .out_phase_after (result.data.phase_after)
);
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the servo pulse train scheduler: random and directed items.
`timescale 1ns / 1ps
module tb_top;
  import sps_pkg::*;

  localparam int N_CH = 8;
  localparam int CH_W = $clog2(N_CH);
  localparam logic [3:0] PH_RESET = 4'd0;
  localparam logic [3:0] PH_FIRST = 4'd1;
  localparam logic [3:0] PH_PAUSE = 4'(N_CH + 1);
  localparam int N_SETTINGS = 8;
  localparam int RAND_ITEMS = 178;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 10;

  class pulse_train_scoreboard;
    logic [15:0] min_us;
    logic [15:0] max_us;
    logic [7:0]  tick_rate;
    logic [31:0] frame_len;
    logic [15:0] width_us [N_CH];
    logic [3:0]  seq_phase;
    logic [31:0] pause_left;
    sps_result_t due_q [$];
    int errors, n_items, n_matches, n_ignored, n_results, n_short_first, n_dry_pause;

    function new();
      min_us     = MIN_PULSE_RST;
      max_us     = MAX_PULSE_RST;
      tick_rate  = TICKS_US_RST;
      frame_len  = FRAME_RST;
      foreach (width_us[i]) width_us[i] = MIDPOINT_USEC;
      seq_phase  = PH_RESET;
      pause_left = FRAME_RST;
    endfunction

    function logic [31:0] ticks(logic [15:0] us);
      return {16'd0, us} * {24'd0, tick_rate};
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_MIN_PULSE: min_us = val[15:0];
        CFG_MAX_PULSE: max_us = val[15:0];
        CFG_TICKS_US:  tick_rate = val[7:0];
        CFG_FRAME:     frame_len = val;
        default: ;
      endcase
    endfunction

    // Accepted input: update widths or step the frame and queue the match result.
    function void note_item(sps_item_t it);
      sps_result_t r;
      logic [15:0] w;
      logic [31:0] t;
      logic [31:0] rp;
      n_items++;
      if (it.kind == KIND_SET) begin
        if (it.channel >= N_CH) begin
          n_ignored++;
          return;
        end
        // raise to min first, then lower to max: crossed limits give max
        w = it.pulse_usec;
        if (w < min_us) w = min_us;
        if (w > max_us) w = max_us;
        width_us[it.channel[CH_W-1:0]] = w;
        return;
      end
      n_matches++;
      r = '0;
      rp = ticks({9'd0, RESET_PULSE_USEC});
      if (seq_phase == PH_RESET) begin
        pause_left = frame_len;
        r.next_interval = rp;
        r.reset_level = 1'b1;
        seq_phase = PH_FIRST;
      end else if (seq_phase == PH_FIRST) begin
        t = ticks(width_us[0]);
        if (t < rp) n_short_first++;
        r.next_interval = (t > rp) ? t - rp : 32'd0;
        pause_left = (pause_left > t) ? pause_left - t : 32'd0;
        r.clock_low = 1'b1;
        seq_phase = seq_phase + 4'd1;
      end else if (seq_phase >= PH_PAUSE) begin
        if (pause_left == 0) n_dry_pause++;
        r.next_interval = pause_left;
        seq_phase = PH_RESET;
      end else begin
        t = ticks(width_us[CH_W'(seq_phase - 4'd1)]);
        r.next_interval = t;
        pause_left = (pause_left > t) ? pause_left - t : 32'd0;
        r.clock_low = 1'b1;
        seq_phase = seq_phase + 4'd1;
      end
      r.phase_after = seq_phase;
      due_q.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(sps_result_t got);
      sps_result_t want;
      n_results++;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none got interval %0d phase %0d",
                 $time, got.next_interval, got.phase_after);
        return;
      end
      want = due_q.pop_front();
      field_check("next_interval", want.next_interval, got.next_interval);
      field_check("reset_level", 32'(want.reset_level), 32'(got.reset_level));
      field_check("clock_low", 32'(want.clock_low), 32'(got.clock_low));
      field_check("phase_after", 32'(want.phase_after), 32'(got.phase_after));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit no_gaps;
  pulse_train_scoreboard sb;

  sps_item_if   item_ch();
  sps_result_if result_ch();

  servo_pulse_train_scheduler #(.CHANNELS(N_CH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sps_item_t mk_item(logic kind, logic [3:0] ch, logic [15:0] us);
    sps_item_t it;
    it.kind = kind;
    it.channel = ch;
    it.pulse_usec = us;
    return it;
  endfunction

  function automatic sps_item_t rand_item();
    sps_item_t it;
    int r;
    logic [15:0] lo;
    logic [15:0] hi;
    r = $urandom_range(0, 99);
    it = mk_item(KIND_MATCH, 4'($urandom), 16'($urandom));
    if (r >= 55) begin
      it.kind = KIND_SET;
      if (r < 90) begin
        it.channel = 4'($urandom_range(0, N_CH - 1));
        lo = (sb.min_us < sb.max_us) ? sb.min_us : sb.max_us;
        hi = (sb.min_us < sb.max_us) ? sb.max_us : sb.min_us;
        if ($urandom_range(0, 1)) it.pulse_usec = 16'($urandom_range(lo, hi));
      end else begin
        it.channel = 4'($urandom_range(N_CH, 15));
      end
    end
    return it;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_item(input sps_item_t it, input int gap);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (sb.due_q.size() != 0) @(negedge clk);
    // a trailing set item may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Result sink: random stalls, plus one long hold so the block backs up.
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && sb.n_results >= HOLD_AFTER) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        stall--;
      end else begin
        result_ch.ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) sb.check_result(result_ch.data);
  end

  initial begin
    logic [15:0] lo;
    logic [15:0] hi;
    logic [7:0]  rate;
    logic [31:0] frame;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    no_gaps = 1'b0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: full frame on reset widths, clamping at both limits, ignored channels.
    repeat (11) send_item(mk_item(KIND_MATCH, 4'($urandom), 16'($urandom)), pick_gap());
    send_item(mk_item(KIND_SET, 4'd0, 16'd0), pick_gap());
    send_item(mk_item(KIND_SET, 4'd7, 16'hFFFF), pick_gap());
    send_item(mk_item(KIND_SET, 4'd8, 16'd1234), pick_gap());
    send_item(mk_item(KIND_SET, 4'd15, 16'hFFFF), pick_gap());
    send_item(mk_item(KIND_SET, 4'd3, 16'd1700), pick_gap());
    send_item(mk_item(KIND_SET, 4'd1, 16'hAAAA), pick_gap());
    send_item(mk_item(KIND_SET, 4'd2, 16'h5555), pick_gap());
    repeat (7) send_item(mk_item(KIND_MATCH, 4'($urandom), 16'($urandom)), pick_gap());

    for (int s = 0; s < N_SETTINGS; s++) begin
      if (s > 0) begin
        item_ch.valid <= 1'b0;
        wait_idle();
        case (s)
          1: begin lo = 16'd100;   hi = 16'hFFFF; rate = 8'd255; frame = 32'hFFFF_FFFF; end
          // crossed limits, every pause runs dry
          2: begin lo = 16'hFFFF; hi = 16'd100;  rate = 8'd1;   frame = 32'd0;         end
          // zero tick rate
          3: begin lo = 16'd100;   hi = 16'd100;  rate = 8'd0;   frame = 32'd5000;      end
          // first channel shorter than the reset pulse
          4: begin lo = 16'd50;    hi = 16'd90;   rate = 8'd200; frame = 32'd100000;    end
          default: begin
            lo = 16'($urandom_range(100, 3000));
            hi = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(100, lo))
                                              : 16'($urandom_range(lo, 65535));
            rate = 8'($urandom_range(1, 255));
            frame = $urandom_range(0, 1) ? $urandom_range(0, 2_000_000) : $urandom;
          end
        endcase
        write_reg(CFG_MIN_PULSE, {16'd0, lo});
        write_reg(CFG_MAX_PULSE, {16'd0, hi});
        write_reg(CFG_TICKS_US, {24'd0, rate});
        write_reg(CFG_FRAME, frame);
        cfg_we <= 1'b0;
      end
      no_gaps = (s == 2 || s == 5);
      repeat (RAND_ITEMS) send_item(rand_item(), pick_gap());
    end

    item_ch.valid <= 1'b0;
    wait_idle();
    $display("Run covered %0d items (%0d timer matches, %0d out-of-range sets) over %0d settings.",
             sb.n_items, sb.n_matches, sb.n_ignored, N_SETTINGS);
    $display("Checked %0d results; %0d short first pulses, %0d empty pauses, one %0d-cycle hold.",
             sb.n_results, sb.n_short_first, sb.n_dry_pause, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/sps_pkg.sv
src/sps_if.sv
src/servo_pulse_train_scheduler.sv
src/sps_checker.sv
dv/tb_top.sv
